[hdl/toy_cpu_instruction_execute_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the instruction execute block
// Shared property shapes used by the checker.
// ----------------------------------------------------------------------------
`ifndef TOY_CPU_INSTRUCTION_EXECUTE_MACROS_SVH
`define TOY_CPU_INSTRUCTION_EXECUTE_MACROS_SVH

// Next-cycle implication, muted while reset is high.
`define TCX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcx assertion failed");

// Next-cycle implication that also runs through reset.
`define TCX_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tcx reset assertion failed");

`endif

[hdl/tcx_pkg.sv]
// ----------------------------------------------------------------------------
// tcx_pkg
// Opcodes and word formats of the instruction execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcx_pkg;

  localparam logic [3:0] OP_LD  = 4'd0;
  localparam logic [3:0] OP_ST  = 4'd1;
  localparam logic [3:0] OP_LDI = 4'd2;
  localparam logic [3:0] OP_STI = 4'd3;
  localparam logic [3:0] OP_LIT = 4'd4;
  localparam logic [3:0] OP_MOV = 4'd5;
  localparam logic [3:0] OP_ADD = 4'd6;
  localparam logic [3:0] OP_SUB = 4'd7;
  localparam logic [3:0] OP_MUL = 4'd8;
  localparam logic [3:0] OP_DIV = 4'd9;
  localparam logic [3:0] OP_AND = 4'd10;
  localparam logic [3:0] OP_OR  = 4'd11;
  localparam logic [3:0] OP_JZ  = 4'd12;
  localparam logic [3:0] OP_EQ  = 4'd13;
  localparam logic [3:0] OP_LT  = 4'd14;
  localparam logic [3:0] OP_NOP = 4'd15;

  typedef struct packed {
    logic [3:0] opcode;
    logic [3:0] dest_reg;
    logic [7:0] operand_byte;
  } insn_t;

  typedef struct packed {
    logic [15:0] pc_after;
    logic        reg_written;
    logic [7:0]  reg_value;
    logic        mem_written;
    logic [7:0]  mem_addr;
    logic [7:0]  mem_value;
  } result_t;

endpackage

`default_nettype wire

[hdl/tcx_regfile.sv]
// ----------------------------------------------------------------------------
// tcx_regfile
// Register file: synchronous memory, two read ports, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcx_regfile #(
  parameter int NUM_REGS   = 16,
  parameter int DATA_WIDTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(NUM_REGS)-1:0] rd_addr_a,
  input  wire logic [$clog2(NUM_REGS)-1:0] rd_addr_b,
  output logic      [DATA_WIDTH-1:0]       rd_data_a,
  output logic      [DATA_WIDTH-1:0]       rd_data_b,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(NUM_REGS)-1:0] wr_addr,
  input  wire logic [DATA_WIDTH-1:0]       wr_data
);

  logic [DATA_WIDTH-1:0] regs [NUM_REGS];
  logic [NUM_REGS-1:0]   vld;

  // valid bits stand in for the reset clear of the array
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      regs[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= vld[rd_addr_a] ? regs[rd_addr_a] : '0;
      rd_data_b <= vld[rd_addr_b] ? regs[rd_addr_b] : '0;
    end
  end

endmodule

`default_nettype wire

[hdl/tcx_dmem.sv]
// ----------------------------------------------------------------------------
// tcx_dmem
// Data memory: synchronous, one read port, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcx_dmem #(
  parameter int MEM_DEPTH  = 256,
  parameter int DATA_WIDTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MEM_DEPTH)-1:0] rd_addr,
  output logic      [DATA_WIDTH-1:0]        rd_data,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MEM_DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_WIDTH-1:0]        wr_data
);

  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]  vld;

  // unwritten words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

`default_nettype wire

[hdl/tcx_div.sv]
// ----------------------------------------------------------------------------
// tcx_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcx_div #(
  parameter int DATA_WIDTH = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output logic                       done,
  output logic      [DATA_WIDTH-1:0] quotient
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH:0]   rem;
  logic [DATA_WIDTH:0]   rem_next;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH-1:0] dvs;
  logic                  ge;

  assign shifted  = {rem[DATA_WIDTH-1:0], quotient[DATA_WIDTH-1]};
  assign ge       = shifted >= {1'b0, dvs};
  assign rem_next = ge ? (shifted - {1'b0, dvs}) : shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift the dividend out of the quotient register as quotient bits enter
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[DATA_WIDTH-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[hdl/toy_cpu_instruction_execute.sv]
// ----------------------------------------------------------------------------
// toy_cpu_instruction_execute
// Executes one instruction word against a register file, data memory and PC.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one instruction word:
//   opcode, dest_reg, operand_byte. res channel (res_valid / res_stall / res)
//   returns exactly one result word per instruction: new PC, register write
//   flag and value, memory store flag, address and value.
//   Timing: the result word is loaded into the output register as write back
//   fires, and the next instruction is taken only once the block is back in
//   idle. A divide by a nonzero register adds a pass through the bit-serial
//   divider. The sequence is: register file read, data memory read, execute,
//   divider if needed, write back. cmd_stall is high from acceptance until
//   write back completes. Reset clears the PC, the register and memory
//   valid bits (all state reads as zero) and the output valid flag. While
//   res_stall holds the result word, write back waits, so state is committed
//   only as the word is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module toy_cpu_instruction_execute import tcx_pkg::*; #(
  parameter int NUM_REGS   = 16,
  parameter int DATA_WIDTH = 8,
  parameter int MEM_DEPTH  = 256,
  parameter int PC_WIDTH   = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cmd_valid,
  output logic         cmd_stall,
  input  wire insn_t   cmd,
  output logic         res_valid,
  input  wire logic    res_stall,
  output result_t      res
);

  localparam int RAW = $clog2(NUM_REGS);
  localparam int MAW = $clog2(MEM_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REG  = 3'd1;
  localparam logic [2:0] S_MEM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  // Reduce an index modulo the register count: up to four compare/subtract
  // steps, since the quotient of a 4-bit value fits in 4 bits.
  function automatic logic [RAW-1:0] reg_index(input logic [3:0] v);
    logic [7:0] r;
    r = {4'b0, v};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (8'(NUM_REGS) << k)) begin
        r = r - (8'(NUM_REGS) << k);
      end
    end
    return RAW'(r);
  endfunction

  // Same for memory addresses: an 8-bit value over a depth of at least 16.
  function automatic logic [MAW-1:0] mem_index(input logic [7:0] v);
    logic [11:0] r;
    r = {4'b0, v};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (12'(MEM_DEPTH) << k)) begin
        r = r - (12'(MEM_DEPTH) << k);
      end
    end
    return MAW'(r);
  endfunction

  logic [2:0]            state;
  logic [PC_WIDTH-1:0]   pc;
  logic [PC_WIDTH-1:0]   pc_next;

  // instruction held while it executes
  logic [3:0]            op_q;
  logic [7:0]            lit_q;
  logic [RAW-1:0]        d_q;

  // execute results
  logic                  rw_q;
  logic [DATA_WIDTH-1:0] rv_q;
  logic                  mw_q;
  logic [MAW-1:0]        ma_q;
  logic [DATA_WIDTH-1:0] mv_q;
  logic                  jump_q;

  logic                  rw;
  logic [DATA_WIDTH-1:0] rv;
  logic                  mw;
  logic [MAW-1:0]        ma;
  logic [DATA_WIDTH-1:0] mv;
  logic                  jump;
  logic                  div_go;

  logic                  accept;
  logic                  wb_fire;

  logic [DATA_WIDTH-1:0] rf_a;
  logic [DATA_WIDTH-1:0] rf_b;
  logic [DATA_WIDTH-1:0] dm_q;
  logic [MAW-1:0]        dm_raddr;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_q;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  // commit only when the output register is free or draining this cycle
  assign wb_fire   = (state == S_WB) && (!res_valid || !res_stall);

  // ---------------------------------------------------------------- storage
  tcx_regfile #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (reg_index(cmd.dest_reg)),
    .rd_addr_b (reg_index(cmd.operand_byte[7:4])),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr_en     (wb_fire && rw_q),
    .wr_addr   (d_q),
    .wr_data   (rv_q)
  );

  // ld reads at the literal, ldi at the source register's value
  assign dm_raddr = (op_q == OP_LDI) ? mem_index(rf_b[7:0]) : mem_index(lit_q);

  tcx_dmem #(
    .MEM_DEPTH  (MEM_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == S_REG),
    .rd_addr (dm_raddr),
    .rd_data (dm_q),
    .wr_en   (wb_fire && mw_q),
    .wr_addr (ma_q),
    .wr_data (mv_q)
  );

  // divider starts as soon as both operands are out of the register file
  tcx_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == S_REG) && (op_q == OP_DIV) && (rf_b != '0)),
    .dividend (rf_a),
    .divisor  (rf_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------- execute
  always_comb begin
    rw     = 1'b0;
    rv     = '0;
    mw     = 1'b0;
    ma     = '0;
    mv     = '0;
    jump   = 1'b0;
    div_go = 1'b0;
    unique case (op_q)
      OP_LD:  begin rw = 1'b1; rv = dm_q; end
      OP_ST:  begin mw = 1'b1; ma = mem_index(lit_q); mv = rf_a; end
      OP_LDI: begin rw = 1'b1; rv = dm_q; end
      OP_STI: begin mw = 1'b1; ma = mem_index(rf_a[7:0]); mv = rf_b; end
      OP_LIT: begin rw = 1'b1; rv = DATA_WIDTH'(lit_q); end
      OP_MOV: begin rw = 1'b1; rv = rf_b; end
      OP_ADD: begin rw = 1'b1; rv = rf_a + rf_b; end
      OP_SUB: begin rw = 1'b1; rv = rf_a - rf_b; end
      OP_MUL: begin rw = 1'b1; rv = DATA_WIDTH'(rf_a * rf_b); end
      OP_DIV: begin div_go = (rf_b != '0); end
      OP_AND: begin rw = 1'b1; rv = rf_a & rf_b; end
      OP_OR:  begin rw = 1'b1; rv = rf_a | rf_b; end
      OP_JZ:  begin jump = (rf_a == '0); end
      OP_EQ:  begin rw = 1'b1; rv = DATA_WIDTH'(rf_a == rf_b); end
      OP_LT:  begin rw = 1'b1; rv = DATA_WIDTH'(rf_a < rf_b); end
      OP_NOP: begin end
    endcase
  end

  assign pc_next = pc + (jump_q ? PC_WIDTH'(lit_q) : '0) + PC_WIDTH'(1);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_REG;
          end
        end
        S_REG: begin
          state <= S_MEM;
        end
        S_MEM: begin
          state <= div_go ? S_DIV : S_WB;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          if (wb_fire) begin
            state <= S_IDLE;
            pc    <= pc_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // latch the instruction and the execute results
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= cmd.opcode;
      lit_q <= cmd.operand_byte;
      d_q   <= reg_index(cmd.dest_reg);
    end
    if (state == S_MEM) begin
      rw_q   <= rw;
      rv_q   <= rv;
      mw_q   <= mw;
      ma_q   <= ma;
      mv_q   <= mv;
      jump_q <= jump;
    end else if ((state == S_DIV) && div_done) begin
      rw_q <= 1'b1;
      rv_q <= div_q;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (wb_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      res.pc_after    <= 16'(pc_next);
      res.reg_written <= rw_q;
      res.reg_value   <= rv_q[7:0];
      res.mem_written <= mw_q;
      res.mem_addr    <= 8'(ma_q);
      res.mem_value   <= mv_q[7:0];
    end
  end

endmodule

`default_nettype wire

[hdl/tcx_checker.sv]
// ----------------------------------------------------------------------------
// tcx_checker
// Port-level checks of the instruction execute block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "toy_cpu_instruction_execute_macros.svh"

module tcx_checker import tcx_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    cmd_valid,
  input wire logic    cmd_stall,
  input wire insn_t   cmd,
  input wire logic    res_valid,
  input wire logic    res_stall,
  input wire result_t res
);

  // block comes out of reset empty and ready
  `TCX_ASSERT_RST(a_reset_idle, clk, rst, !res_valid && !cmd_stall)

  // one instruction at a time: acceptance closes the input
  `TCX_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall)

  // a stalled instruction word holds
  `TCX_ASSERT_NEXT(a_cmd_hold, clk, rst, cmd_valid && cmd_stall, $stable(cmd))

  // a stalled result word holds
  `TCX_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res))

endmodule

bind toy_cpu_instruction_execute tcx_checker u_tcx_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire

[tb/sv/toy_cpu_instruction_execute_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// toy_cpu_instruction_execute_tb
// Self-checking bench for the instruction execute block. Instruction words
// go in on the cmd channel; a shadow copy of the register file, data memory
// and PC works out each result word, which is checked field by field as it
// leaves on the res channel. Directed cases come first, then a PC wrap run,
// random programs, back-pressure, a drained pause and a final clean stream.
// ----------------------------------------------------------------------------

module toy_cpu_instruction_execute_tb;
  import tcx_pkg::*;

  // Result can lag by the sequencer steps plus the bit-serial divide; allow some slack.
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 60;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    cmd_valid = 1'b0;
  logic    cmd_stall;
  insn_t   cmd       = '0;
  logic    res_valid;
  logic    res_stall = 1'b0;
  result_t res;

  toy_cpu_instruction_execute DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow architectural state and the result words still owed by the block
  // --------------------------------------------------------------------------
  logic [7:0]  arch_regs [16];
  logic [7:0]  arch_mem  [256];
  logic [15:0] arch_pc;
  result_t     pending_results [$];

  int err_count    = 0;
  int n_issued     = 0;
  int n_checked    = 0;
  int n_jz_taken   = 0;
  int n_div_zero   = 0;

  // Idling controls: quiet flags switch off random gaps on one side;
  // hold_req asks the receiver for one long stall stretch.
  bit cmd_quiet = 1'b0;
  bit res_quiet = 1'b0;
  bit hold_req  = 1'b0;

  // Execute one instruction against the shadow state and return the word
  // the block must produce for it.
  function automatic result_t retire_insn(insn_t w);
    result_t    r;
    logic [3:0] d;
    logic [3:0] s;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] lit;
    logic [7:0] rv;
    logic [7:0] mv;
    logic [7:0] ma;
    logic       rw;
    logic       mw;
    d   = w.dest_reg;
    lit = w.operand_byte;
    s   = lit[7:4];
    a   = arch_regs[d];
    b   = arch_regs[s];
    rw  = 1'b0;
    mw  = 1'b0;
    rv  = '0;
    mv  = '0;
    ma  = '0;
    case (w.opcode)
      OP_LD: begin
        rw = 1'b1;
        rv = arch_mem[lit];
      end
      OP_ST: begin
        mw = 1'b1;
        ma = lit;
        mv = a;
      end
      OP_LDI: begin
        rw = 1'b1;
        rv = arch_mem[b];
      end
      OP_STI: begin
        mw = 1'b1;
        ma = a;
        mv = b;
      end
      OP_LIT: begin
        rw = 1'b1;
        rv = lit;
      end
      OP_MOV: begin
        rw = 1'b1;
        rv = b;
      end
      OP_ADD: begin
        rw = 1'b1;
        rv = a + b;
      end
      OP_SUB: begin
        rw = 1'b1;
        rv = a - b;
      end
      OP_MUL: begin
        rw = 1'b1;
        rv = a * b;
      end
      OP_DIV: begin
        // Divide by zero leaves the destination alone.
        if (b != 8'd0) begin
          rw = 1'b1;
          rv = a / b;
        end else begin
          n_div_zero++;
        end
      end
      OP_AND: begin
        rw = 1'b1;
        rv = a & b;
      end
      OP_OR: begin
        rw = 1'b1;
        rv = a | b;
      end
      OP_JZ: begin
        if (a == 8'd0) begin
          arch_pc = arch_pc + {8'd0, lit};
          n_jz_taken++;
        end
      end
      OP_EQ: begin
        rw = 1'b1;
        rv = (a == b) ? 8'd1 : 8'd0;
      end
      OP_LT: begin
        rw = 1'b1;
        rv = (a < b) ? 8'd1 : 8'd0;
      end
      default: ;
    endcase
    if (rw) arch_regs[d] = rv;
    if (mw) arch_mem[ma] = mv;
    arch_pc = arch_pc + 16'd1;

    r.pc_after    = arch_pc;
    r.reg_written = rw;
    r.reg_value   = rw ? rv : 8'd0;
    r.mem_written = mw;
    r.mem_addr    = mw ? ma : 8'd0;
    r.mem_value   = mw ? mv : 8'd0;
    return r;
  endfunction

  function automatic insn_t make_insn(logic [3:0] op, logic [3:0] d, logic [7:0] b);
    insn_t w;
    w.opcode       = op;
    w.dest_reg     = d;
    w.operand_byte = b;
    return w;
  endfunction

  // One line per mismatch, and count it.
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one word at the falling edge and hold it until accepted. A random
  // idle gap may come first; the word that was just taken
  // is then dropped at the first falling edge after its acceptance.
  task automatic issue_insn(input insn_t w);
    if (!cmd_quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    cmd       <= w;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    pending_results.push_back(retire_insn(w));
    n_issued++;
  endtask

  task automatic cmd_drop();
    @(negedge clk);
    cmd_valid <= 1'b0;
  endtask

  // Stop offering, wait until every owed word is back, then let the block
  // settle before anything else goes in.
  task automatic drain_results();
    cmd_drop();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic insn_t random_insn();
    logic [3:0] op;
    // Seed registers with literals often so arithmetic, compares and
    // indirect accesses see a spread of values, zero included.
    case ($urandom_range(0, 7))
      0, 1:    op = OP_LIT;
      default: op = 4'($urandom_range(0, 15));
    endcase
    if (op == OP_LIT && $urandom_range(0, 5) == 0)
      return make_insn(op, 4'($urandom_range(0, 15)), 8'd0);
    return make_insn(op, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: random stall bursts, one long hold on request, none
  // when quiet.
  // --------------------------------------------------------------------------
  int hold_left  = 0;
  int burst_left = 0;
  bit burst_val  = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      res_stall <= 1'b1;
    end else if (res_quiet) begin
      res_stall <= 1'b0;
    end else if (burst_left > 0) begin
      res_stall  <= burst_val;
      burst_left <= burst_left - 1;
    end else begin
      // Start a new burst, stalled or free.
      burst_val  = ($urandom_range(0, 2) == 0);
      burst_left <= $urandom_range(0, 5);
      res_stall  <= burst_val;
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted word with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing owed", 16'(res.pc_after), 16'd0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (res.pc_after !== want.pc_after)
          report_mismatch("pc_after", res.pc_after, want.pc_after);
        if (res.reg_written !== want.reg_written)
          report_mismatch("reg_written", 16'(res.reg_written), 16'(want.reg_written));
        if (res.reg_value !== want.reg_value)
          report_mismatch("reg_value", 16'(res.reg_value), 16'(want.reg_value));
        if (res.mem_written !== want.mem_written)
          report_mismatch("mem_written", 16'(res.mem_written), 16'(want.mem_written));
        if (res.mem_addr !== want.mem_addr)
          report_mismatch("mem_addr", 16'(res.mem_addr), 16'(want.mem_addr));
        if (res.mem_value !== want.mem_value)
          report_mismatch("mem_value", 16'(res.mem_value), 16'(want.mem_value));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every opcode once at least, field extremes, divide by zero, jumps taken
  // and not taken, a load from a word never stored, full register indexes.
  task automatic test_directed();
    issue_insn(make_insn(OP_LIT, 4'd0,  8'h00));
    issue_insn(make_insn(OP_LIT, 4'd15, 8'hFF));
    issue_insn(make_insn(OP_LIT, 4'd1,  8'h80));
    issue_insn(make_insn(OP_LIT, 4'd2,  8'h03));
    issue_insn(make_insn(OP_ADD, 4'd15, 8'hF0));   // wraps past 0xFF
    issue_insn(make_insn(OP_SUB, 4'd0,  8'hF0));   // borrows below zero
    issue_insn(make_insn(OP_MUL, 4'd1,  8'h10));   // 0x80 squared drops out
    issue_insn(make_insn(OP_DIV, 4'd15, 8'h20));
    issue_insn(make_insn(OP_DIV, 4'd15, 8'h1F));   // divisor register is zero
    issue_insn(make_insn(OP_AND, 4'd15, 8'h2F));
    issue_insn(make_insn(OP_OR,  4'd1,  8'h20));
    issue_insn(make_insn(OP_EQ,  4'd2,  8'h20));
    issue_insn(make_insn(OP_LT,  4'd0,  8'hF0));
    issue_insn(make_insn(OP_LT,  4'd15, 8'h00));
    issue_insn(make_insn(OP_MOV, 4'd3,  8'hF0));
    issue_insn(make_insn(OP_ST,  4'd15, 8'hFF));
    issue_insn(make_insn(OP_LD,  4'd4,  8'hFF));
    issue_insn(make_insn(OP_LD,  4'd5,  8'h00));   // never stored, reads zero
    issue_insn(make_insn(OP_LIT, 4'd6,  8'h10));
    issue_insn(make_insn(OP_STI, 4'd6,  8'hF0));
    issue_insn(make_insn(OP_LDI, 4'd7,  8'h60));
    issue_insn(make_insn(OP_JZ,  4'd1,  8'hFF));   // nonzero: falls through
    issue_insn(make_insn(OP_JZ,  4'd5,  8'hFF));   // zero: jumps
    issue_insn(make_insn(OP_JZ,  4'd5,  8'h00));
    issue_insn(make_insn(OP_NOP, 4'd15, 8'hFF));
  endtask

  // Taken jumps of 0xFF move the PC by 256 each, so this wraps 16 bits.
  task automatic test_pc_wrap();
    issue_insn(make_insn(OP_LIT, 4'd0, 8'h00));
    repeat (260) issue_insn(make_insn(OP_JZ, 4'd0, 8'hFF));
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) issue_insn(random_insn());
  endtask

  // Hold the result side for a long stretch while words keep coming, so the
  // block fills and stalls its command input.
  task automatic test_backpressure();
    hold_req  = 1'b1;
    cmd_quiet = 1'b1;
    repeat (15) issue_insn(random_insn());
    cmd_quiet = 1'b0;
  endtask

  // Pause the sender until every owed word is back, then resume.
  task automatic test_drain_pause();
    repeat (20) issue_insn(random_insn());
    drain_results();
    repeat (20) issue_insn(random_insn());
  endtask

  // Final stretch with no idling on either side.
  task automatic test_quiet_stream(input int count);
    cmd_quiet = 1'b1;
    res_quiet = 1'b1;
    repeat (count) issue_insn(random_insn());
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    arch_pc = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_pc_wrap();
    test_random_mix(250);
    test_backpressure();
    test_drain_pause();
    test_quiet_stream(60);

    // Bounded wait for the last words; anything still owed is a failure.
    cmd_drop();
    waited = 0;
    while (pending_results.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch("result words never returned", 16'(pending_results.size()), 16'd0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d instructions and checked %0d result words", n_issued, n_checked);
    $display("(%0d jumps taken, %0d divides by zero).", n_jz_taken, n_div_zero);
    $display("Covered all opcodes, a PC wrap, a long result hold, a drained pause and a clean stream.");
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #800000;
    $display("Timeout with %0d result words still owed", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

[toy_cpu_instruction_execute.f]
+incdir+hdl
hdl/tcx_pkg.sv
hdl/tcx_regfile.sv
hdl/tcx_dmem.sv
hdl/tcx_div.sv
hdl/toy_cpu_instruction_execute.sv
hdl/tcx_checker.sv
tb/sv/toy_cpu_instruction_execute_tb.sv
